// ----- rtl/price_level_book_top_defines.svh -----
// ----------------------------------------------------------------------------
// price level book assertion macros
// shared concurrent check templates, sampled on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef PRICE_LEVEL_BOOK_TOP_DEFINES_SVH
`define PRICE_LEVEL_BOOK_TOP_DEFINES_SVH

// same-cycle implication
`define PLB_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/plb_pkg.sv -----
// ----------------------------------------------------------------------------
// plb_pkg
// types and codes shared by the price level book files
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t QTY_MAX = '1;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TRADE  = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  typedef struct packed {
    word_t res;
    logic  carry;
    logic  zero;
  } alu_rsp_t;

  typedef struct packed {
    logic  valid;
    word_t qty;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WIN,
    S_RD,
    S_CALC,
    S_OUT,
    S_LRD,
    S_LCHK,
    S_LOUT,
    S_LEND
  } state_t;

endpackage

// ----- rtl/plb_req_if.sv -----
// ----------------------------------------------------------------------------
// plb_req_if
// request channel: one order book operation per transaction
// ----------------------------------------------------------------------------
interface plb_req_if import plb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        side;
  word_t       price;
  word_t       qty;

  modport source (output valid, opcode, side, price, qty, input ready);
  modport sink (input valid, opcode, side, price, qty, output ready);
endinterface

// ----- rtl/plb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// plb_rsp_if
// result channel: one reported price level per transaction
// ----------------------------------------------------------------------------
interface plb_rsp_if import plb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        out_side;
  word_t       out_price;
  word_t       level_qty;
  logic        present;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, out_side, out_price, level_qty, present, status, last,
                  input ready);
  modport sink (input valid, out_side, out_price, level_qty, present, status, last,
                output ready);
endinterface

// ----- rtl/plb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// plb_cfg_if
// configuration write channel for the base price register
// ----------------------------------------------------------------------------
interface plb_cfg_if import plb_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t base_price;

  modport source (output valid, base_price, input ready);
  modport sink (input valid, base_price, output ready);
endinterface

// ----- rtl/price_level_book_top.sv -----
// ----------------------------------------------------------------------------
// price_level_book_top
// per-side aggregate quantity table for price levels at and above a base price
// new/cancel/trade: after the request transaction the window check (S_WIN),
//   table read (S_RD), shared adder update (S_CALC) and result register lead
//   to the result in S_OUT (from S_WIN directly when the price is outside the
//   window); the next request is taken after the result transaction
// list: each entry of the side is read (S_LRD) and checked (S_LCHK); levels are
//   shown in S_LOUT, the last via S_LEND and S_OUT; output stalls hold the scan
// reset: synchronous; clears base_price, then a clearing pass over all table
//   entries wipes the valid bits before requests are taken
// ----------------------------------------------------------------------------
`include "price_level_book_top_defines.svh"

module price_level_book_top import plb_pkg::*; #(
  parameter int LEVELS = 64
) (
  input  logic       clk,
  input  logic       rst,
  plb_cfg_if.sink    cfg,
  plb_req_if.sink    req,
  plb_rsp_if.source  rsp
);

  localparam int IDX_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // sequencer and control registers
  state_t            state, state_next;
  word_t             base;
  logic [ADDR_W-1:0] clr_addr;
  logic [IDX_W-1:0]  idx;
  logic              at_end;
  logic              pend_valid;

  // captured request
  op_t               op_r;
  logic              side_r;
  word_t             price_r;
  word_t             qty_r;
  logic [IDX_W-1:0]  off;

  // pending list entry, held back so the final one can carry last
  word_t             pend_price;
  word_t             pend_qty;

  // result register
  word_t             out_price;
  word_t             out_qty;
  logic              out_present;
  status_t           out_status;
  logic              out_last;

  // level table: {side, offset} -> {valid, qty}
  entry_t            mem [MEM_DEPTH];
  entry_t            rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // shared arithmetic unit
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // decoded values for the current state
  logic              outside;
  logic              at_end_c;
  word_t             calc_qty;
  logic              calc_present;
  status_t           calc_status;

  plb_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign cfg.ready     = 1'b1;
  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_OUT) || (state == S_LOUT);
  assign rsp.out_side  = side_r;
  assign rsp.out_price = out_price;
  assign rsp.level_qty = out_qty;
  assign rsp.present   = out_present;
  assign rsp.status    = out_status;
  assign rsp.last      = out_last;

  // next state, adder operands, table access
  always_comb begin
    state_next   = state;
    alu_req      = '{op: ALU_ADD, a: '0, b: '0};
    mem_we       = 1'b0;
    mem_waddr    = {side_r, off};
    mem_wdata    = '{valid: 1'b0, qty: '0};
    mem_raddr    = {side_r, off};
    outside      = 1'b0;
    at_end_c     = (idx == IDX_W'(LEVELS - 1));
    calc_qty     = '0;
    calc_present = 1'b0;
    calc_status  = ST_OK;

    case (state)
      S_CLEAR: begin
        // wipe one table entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.opcode == OP_LIST) ? S_LRD : S_WIN;
        end
      end
      S_WIN: begin
        // offset = price - base, must not borrow and must index the table
        alu_req    = '{op: ALU_SUB, a: price_r, b: base};
        outside    = alu_rsp.carry || (alu_rsp.res >= word_t'(LEVELS));
        state_next = outside ? S_OUT : S_RD;
      end
      S_RD: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        state_next = S_OUT;
        if (op_r == OP_NEW) begin
          alu_req = '{op: ALU_ADD, a: rdata.qty, b: qty_r};
          if (rdata.valid) begin
            calc_qty = alu_rsp.carry ? QTY_MAX : alu_rsp.res;
          end else begin
            calc_qty = qty_r;
          end
          calc_present = 1'b1;
          mem_we       = 1'b1;
          mem_wdata    = '{valid: 1'b1, qty: calc_qty};
        end else if (!rdata.valid) begin
          calc_status = ST_NOT_FOUND;
        end else begin
          // removal of at least the level quantity deletes the level
          alu_req = '{op: ALU_SUB, a: rdata.qty, b: qty_r};
          mem_we  = 1'b1;
          if (alu_rsp.carry || alu_rsp.zero) begin
            mem_wdata = '{valid: 1'b0, qty: '0};
          end else begin
            calc_qty     = alu_rsp.res;
            calc_present = 1'b1;
            mem_wdata    = '{valid: 1'b1, qty: alu_rsp.res};
          end
        end
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      S_LRD: begin
        mem_raddr  = {side_r, idx};
        state_next = S_LCHK;
      end
      S_LCHK: begin
        // price of the scanned entry
        alu_req = '{op: ALU_ADD, a: base, b: word_t'(idx)};
        if (rdata.valid && pend_valid) begin
          state_next = S_LOUT;
        end else if (at_end_c) begin
          state_next = S_LEND;
        end else begin
          state_next = S_LRD;
        end
      end
      S_LOUT: begin
        if (rsp.ready) begin
          state_next = at_end ? S_LEND : S_LRD;
        end
      end
      S_LEND: begin
        state_next = pend_valid ? S_OUT : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      base       <= '0;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      idx        <= '0;
      at_end     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        base <= cfg.base_price;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          idx        <= '0;
          pend_valid <= 1'b0;
        end
        S_LCHK: begin
          at_end <= at_end_c;
          if (!at_end_c) begin
            idx <= idx + 1'b1;
          end
          if (rdata.valid) begin
            pend_valid <= 1'b1;
          end
        end
        S_LEND: begin
          pend_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // request capture, pending entry and result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r    <= op_t'(req.opcode);
        side_r  <= req.side;
        price_r <= req.price;
        qty_r   <= req.qty;
      end
      S_WIN: begin
        off         <= alu_rsp.res[IDX_W-1:0];
        out_price   <= price_r;
        out_qty     <= '0;
        out_present <= 1'b0;
        out_status  <= ST_OUTSIDE;
        out_last    <= 1'b1;
      end
      S_CALC: begin
        out_qty     <= calc_qty;
        out_present <= calc_present;
        out_status  <= calc_status;
      end
      S_LCHK: begin
        if (rdata.valid) begin
          pend_price <= alu_rsp.res;
          pend_qty   <= rdata.qty;
          if (pend_valid) begin
            out_price   <= pend_price;
            out_qty     <= pend_qty;
            out_present <= 1'b1;
            out_status  <= ST_OK;
            out_last    <= 1'b0;
          end
        end
      end
      S_LEND: begin
        out_price   <= pend_price;
        out_qty     <= pend_qty;
        out_present <= 1'b1;
        out_status  <= ST_OK;
        out_last    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // level table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // checks
  `PLB_ASSERT_SAME(a_one_item, rsp.valid, !req.ready, "request taken while a result waits")
  `PLB_ASSERT_NEXT(a_accept_seq, req.valid && req.ready,
                   state == S_WIN || state == S_LRD, "accepted request not processed")
  `PLB_ASSERT_SAME(a_outside_empty, rsp.valid && rsp.status == ST_OUTSIDE,
                   !rsp.present && rsp.level_qty == '0, "outside result carries a level")
  `PLB_ASSERT_SAME(a_present_ok, rsp.valid && rsp.present,
                   rsp.status == ST_OK, "present level with error status")

endmodule

// ----- rtl/plb_alu.sv -----
// ----------------------------------------------------------------------------
// plb_alu
// shared 32-bit add / subtract unit with carry-borrow and zero flags
// ----------------------------------------------------------------------------
module plb_alu import plb_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WORD_W:0] sum;

  always_comb begin
    case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
      default: sum = '0;
    endcase
    rsp.res   = sum[WORD_W-1:0];
    rsp.carry = sum[WORD_W];
    rsp.zero  = (sum[WORD_W-1:0] == '0);
  end

endmodule
